/* rtl/core/lors_pkg.sv */
// ----------------------------------------------------------------------------
// Lane occupancy row scanner package
// Shared types and constants: pixel and column widths, count limits and
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lors_pkg;

	localparam int NUM_LANES = 3;

	typedef logic [7:0]  pixel_t;
	typedef logic [11:0] col_t;
	typedef logic [11:0] count_t;
	typedef logic [9:0]  lane_row_t;
	typedef logic [10:0] out_row_t;
	typedef logic [9:0]  cfg_data_t;

	localparam pixel_t    STRONG_LEVEL   = 8'd250;
	localparam count_t    COUNT_MAX      = 12'd4095;
	localparam lane_row_t SCAN_ROW_RESET = 10'd511;

	typedef enum logic [0:0] {
		REG_ROW_OFFSET    = 1'b0,
		REG_SCAN_LAST_ROW = 1'b1
	} reg_index_t;

	typedef struct packed {
		pixel_t edge_pixel;
		pixel_t eroded_pixel;
		col_t   edge_0;
		col_t   edge_1;
		col_t   edge_2;
		col_t   edge_3;
		logic   row_end;
		logic   frame_end;
	} beat_t;

endpackage

`default_nettype wire

/* rtl/core/lane_occupancy_row_scanner_top.sv */
// ----------------------------------------------------------------------------
// Lane occupancy row scanner
// Counts strong edge pixels per lane and row and reports, at frame end, the
// last qualifying row of each of the three lanes.
// ----------------------------------------------------------------------------
// Usage:
// Pixels of the region arrive in raster order on the input channel
// (in_valid/in_ready), one beat per pixel, with the lane boundaries of
// the current row. A beat with frame_end set yields one result beat on the
// output channel (out_valid/out_ready); other beats yield none.
// Throughput is one pixel per cycle while no frame end waits on a stalled
// result: the block takes a new beat in every cycle, set by the single pass
// from the input register to the state and result registers. When the
// receiver stalls, the result waits in the output register and further
// pixel beats still pass; the next frame end waits in the input register
// and stalls the input until the first result is taken. Reset clears the
// counters, lane state and both registers; row_offset returns to 0 and
// scan_last_row to 511. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once; the user must make them while idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module lane_occupancy_row_scanner_top #(
	parameter int MAX_COLS = 2048,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire lors_pkg::cfg_data_t cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire lors_pkg::pixel_t    edge_pixel,
	input  wire lors_pkg::pixel_t    eroded_pixel,
	input  wire lors_pkg::col_t      edge_0,
	input  wire lors_pkg::col_t      edge_1,
	input  wire lors_pkg::col_t      edge_2,
	input  wire lors_pkg::col_t      edge_3,
	input  wire logic                row_end,
	input  wire logic                frame_end,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     left_found,
	output lors_pkg::out_row_t       left_row,
	output logic                     center_found,
	output lors_pkg::out_row_t       center_row,
	output logic                     right_found,
	output lors_pkg::out_row_t       right_row
);
	import lors_pkg::*;

	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CMPW  = (CW > 12) ? CW : 12;
	localparam int RCMPW = (RW > 10) ? RW : 10;

	lane_row_t row_offset_q;
	lane_row_t scan_last_row_q;

	beat_t s1_q;
	logic  s1_valid_q;
	logic  adv;

	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic [NUM_LANES-1:0] started_q;
	count_t               count_q [NUM_LANES];
	logic [NUM_LANES-1:0] hit_q;
	lane_row_t            hit_row_q [NUM_LANES];

	logic [NUM_LANES-1:0] started_nx;
	count_t               count_nx [NUM_LANES];
	logic [NUM_LANES-1:0] hit_nx;
	lane_row_t            hit_row_nx [NUM_LANES];
	out_row_t             res_row [NUM_LANES];
	logic                 row_end_eff;
	logic                 col_ok;

	logic                 out_valid_q;
	logic [NUM_LANES-1:0] out_found_q;
	out_row_t             out_row_q [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_offset_q    <= '0;
			scan_last_row_q <= SCAN_ROW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_OFFSET:    row_offset_q    <= cfg_data;
				REG_SCAN_LAST_ROW: scan_last_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = s1_valid_q && (!s1_q.frame_end || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_q <= '{edge_pixel: edge_pixel, eroded_pixel: eroded_pixel,
				edge_0: edge_0, edge_1: edge_1, edge_2: edge_2, edge_3: edge_3,
				row_end: row_end, frame_end: frame_end};
		end
	end

	always_comb begin
		col_t             bnd [NUM_LANES+1];
		logic [CMPW-1:0]  col_ext;
		logic [RCMPW-1:0] row_ext;
		logic             row_ok;
		logic             in_lane;
		logic             cnt_inc;
		logic             qual;
		col_t             lane_w;
		logic [15:0]      prod_count;
		logic [15:0]      prod_width;
		bnd[0]      = s1_q.edge_0;
		bnd[1]      = s1_q.edge_1;
		bnd[2]      = s1_q.edge_2;
		bnd[3]      = s1_q.edge_3;
		row_end_eff = s1_q.row_end || s1_q.frame_end;
		col_ok      = col_q < CW'(MAX_COLS);
		col_ext     = CMPW'(col_q);
		row_ext     = RCMPW'(row_q);
		row_ok      = (row_q < RW'(MAX_ROWS)) && (row_ext <= RCMPW'(scan_last_row_q));
		for (int i = 0; i < NUM_LANES; i++) begin
			in_lane = col_ok && (col_ext >= CMPW'(bnd[i])) && (col_ext < CMPW'(bnd[i+1]));
			started_nx[i] = started_q[i] || (in_lane && (s1_q.eroded_pixel > STRONG_LEVEL));
			cnt_inc = in_lane && started_nx[i] && (s1_q.edge_pixel > STRONG_LEVEL)
				&& (count_q[i] != COUNT_MAX);
			count_nx[i] = count_q[i] + count_t'(cnt_inc);
			lane_w     = bnd[i+1] - bnd[i];
			prod_count = (16'(count_nx[i]) << 3) + (16'(count_nx[i]) << 1);
			prod_width = (16'(lane_w) << 1) + 16'(lane_w);
			qual = row_end_eff && row_ok && (bnd[i+1] > bnd[i]) && (prod_count >= prod_width);
			hit_nx[i]     = hit_q[i] || qual;
			hit_row_nx[i] = qual ? row_ext[9:0] : hit_row_q[i];
			res_row[i]    = hit_nx[i]
				? (out_row_t'(hit_row_nx[i]) + out_row_t'(row_offset_q)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			started_q <= '0;
			hit_q     <= '0;
			for (int i = 0; i < NUM_LANES; i++) begin
				count_q[i]   <= '0;
				hit_row_q[i] <= '0;
			end
		end else if (adv) begin
			if (s1_q.frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				started_q <= '0;
				hit_q     <= '0;
				for (int i = 0; i < NUM_LANES; i++) begin
					count_q[i]   <= '0;
					hit_row_q[i] <= '0;
				end
			end else if (row_end_eff) begin
				col_q     <= '0;
				started_q <= '0;
				hit_q     <= hit_nx;
				if (row_q < RW'(MAX_ROWS)) begin
					row_q <= row_q + RW'(1);
				end
				for (int i = 0; i < NUM_LANES; i++) begin
					count_q[i]   <= '0;
					hit_row_q[i] <= hit_row_nx[i];
				end
			end else begin
				started_q <= started_nx;
				if (col_ok) begin
					col_q <= col_q + CW'(1);
				end
				for (int i = 0; i < NUM_LANES; i++) begin
					count_q[i] <= count_nx[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && s1_q.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_q.frame_end) begin
			out_found_q <= hit_nx;
			for (int i = 0; i < NUM_LANES; i++) begin
				out_row_q[i] <= res_row[i];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign left_found   = out_found_q[0];
	assign left_row     = out_row_q[0];
	assign center_found = out_found_q[1];
	assign center_row   = out_row_q[1];
	assign right_found  = out_found_q[2];
	assign right_row    = out_row_q[2];

	a_result_from_frame_end : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q && s1_q.frame_end))
		else $error("result beat without a frame end");

	a_frame_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s1_q.frame_end) |=> (col_q == '0 && row_q == '0 && hit_q == '0
			&& started_q == '0))
		else $error("frame state not cleared after frame end");

	a_column_bound : assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(MAX_COLS))
		else $error("column counter past its limit");

	a_row_bound : assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(MAX_ROWS))
		else $error("row counter past its limit");

	a_not_found_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q[0]) |-> (out_row_q[0] == '0))
		else $error("left row set without a qualifying row");

endmodule

`default_nettype wire

/* tb/lane_occupancy_row_scanner_top_tb.sv */
// ----------------------------------------------------------------------------
// Lane occupancy row scanner testbench
// Streams raster pixel beats with per-row lane boundaries into the scanner
// and checks every frame-end result against a cycle-free prediction of the
// per-lane counting, row qualification and last-row reporting. Both channels
// idle in random bursts, the receiver holds off once for a long stretch, and
// the registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module lane_occupancy_row_scanner_top_tb;

	import lors_pkg::*;

	localparam int SCAN_COLS      = 2048;
	localparam int SCAN_ROWS      = 1024;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct packed {
		logic     left_found;
		out_row_t left_row;
		logic     center_found;
		out_row_t center_row;
		logic     right_found;
		out_row_t right_row;
	} lane_report_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      cfg_we       = 1'b0;
	logic      cfg_index    = 1'b0;
	cfg_data_t cfg_data     = '0;
	logic      in_valid     = 1'b0;
	logic      in_ready;
	beat_t     cur_px       = '0;
	logic      out_valid;
	logic      out_ready    = 1'b0;
	logic      left_found;
	out_row_t  left_row;
	logic      center_found;
	out_row_t  center_row;
	logic      right_found;
	out_row_t  right_row;

	logic      quiet        = 1'b0;
	logic      hold_req     = 1'b0;

	beat_t        pending_pixels [$];
	lane_report_t expected_reports [$];
	int           beats_queued = 0;
	int           beats_taken  = 0;
	int           error_count  = 0;
	int           send_gap     = 0;
	int           sink_gap     = 0;
	int           hold_left    = 0;
	logic         hold_seen    = 1'b0;

	cfg_data_t cfg_row_offset = '0;
	cfg_data_t cfg_scan_last  = SCAN_ROW_RESET;

	logic [11:0] col_pos = '0;
	logic [10:0] row_pos = '0;
	logic        lane_open    [3] = '{default: 1'b0};
	count_t      lane_count   [3] = '{default: '0};
	logic        lane_hit     [3] = '{default: 1'b0};
	lane_row_t   lane_hit_row [3] = '{default: '0};

	lane_occupancy_row_scanner_top #(
		.MAX_COLS(SCAN_COLS),
		.MAX_ROWS(SCAN_ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.edge_pixel(cur_px.edge_pixel),
		.eroded_pixel(cur_px.eroded_pixel),
		.edge_0(cur_px.edge_0),
		.edge_1(cur_px.edge_1),
		.edge_2(cur_px.edge_2),
		.edge_3(cur_px.edge_3),
		.row_end(cur_px.row_end),
		.frame_end(cur_px.frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_found(left_found),
		.left_row(left_row),
		.center_found(center_found),
		.center_row(center_row),
		.right_found(right_found),
		.right_row(right_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	task automatic scan_pixel(input beat_t px);
		col_t         bnd [4];
		out_row_t     shown [3];
		lane_report_t rep;
		logic         at_row_end;
		int           w;
		bnd[0] = px.edge_0;
		bnd[1] = px.edge_1;
		bnd[2] = px.edge_2;
		bnd[3] = px.edge_3;
		at_row_end = px.row_end || px.frame_end;
		if (col_pos < SCAN_COLS) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				if (col_pos >= bnd[i] && col_pos < bnd[i + 1]) begin
					if (px.eroded_pixel > STRONG_LEVEL) lane_open[i] = 1'b1;
					if (lane_open[i] && px.edge_pixel > STRONG_LEVEL &&
					    lane_count[i] < COUNT_MAX) lane_count[i]++;
				end
			end
			col_pos++;
		end
		if (at_row_end) begin
			if (row_pos < SCAN_ROWS && row_pos <= cfg_scan_last) begin
				for (int i = 0; i < NUM_LANES; i++) begin
					if (bnd[i + 1] > bnd[i]) begin
						w = int'(bnd[i + 1]) - int'(bnd[i]);
						if (10 * int'(lane_count[i]) >= 3 * w) begin
							lane_hit[i] = 1'b1;
							lane_hit_row[i] = lane_row_t'(row_pos);
						end
					end
				end
			end
			for (int i = 0; i < NUM_LANES; i++) begin
				lane_open[i] = 1'b0;
				lane_count[i] = '0;
			end
			col_pos = '0;
			if (row_pos < SCAN_ROWS) row_pos++;
		end
		if (px.frame_end) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				shown[i] = lane_hit[i] ?
					out_row_t'(int'(lane_hit_row[i]) + int'(cfg_row_offset)) : '0;
			end
			rep.left_found   = lane_hit[0];
			rep.left_row     = shown[0];
			rep.center_found = lane_hit[1];
			rep.center_row   = shown[1];
			rep.right_found  = lane_hit[2];
			rep.right_row    = shown[2];
			expected_reports = {expected_reports, rep};
			for (int i = 0; i < NUM_LANES; i++) begin
				lane_hit[i] = 1'b0;
				lane_hit_row[i] = '0;
			end
			row_pos = '0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				scan_pixel(cur_px);
				beats_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 9);
					in_valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					cur_px <= pending_pixels.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 9);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		lane_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				report_error("result beat with no frame end pending");
			end else begin
				want = expected_reports.pop_front();
				check_field("left_found", left_found, want.left_found);
				check_field("left_row", left_row, want.left_row);
				check_field("center_found", center_found, want.center_found);
				check_field("center_row", center_row, want.center_row);
				check_field("right_found", right_found, want.right_found);
				check_field("right_row", right_row, want.right_row);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("lane_occupancy_row_scanner_top_tb: done, errors");
		$finish;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic pixel_t pick_level(input int pct);
		return chance(pct) ? pixel_t'($urandom_range(251, 255)) :
		                     pixel_t'($urandom_range(0, 250));
	endfunction

	task automatic push_pixel(input int ed, input int er, input int e0, input int e1,
	                          input int e2, input int e3, input bit re, input bit fe);
		beat_t px;
		px.edge_pixel   = pixel_t'(ed);
		px.eroded_pixel = pixel_t'(er);
		px.edge_0       = col_t'(e0);
		px.edge_1       = col_t'(e1);
		px.edge_2       = col_t'(e2);
		px.edge_3       = col_t'(e3);
		px.row_end      = re;
		px.frame_end    = fe;
		pending_pixels = {pending_pixels, px};
		beats_queued++;
	endtask

	task automatic set_reg(input reg_index_t idx, input int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= cfg_data_t'(val);
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_ROW_OFFSET: begin
				cfg_row_offset = cfg_data_t'(val);
			end
			REG_SCAN_LAST_ROW: begin
				cfg_scan_last = cfg_data_t'(val);
			end
			default: begin
			end
		endcase
	endtask

	task automatic drain();
		while (beats_taken != beats_queued || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_random_frame(input int max_rows, input int max_width);
		int nrows;
		int width;
		int mode;
		int pct_edge;
		int pct_ero;
		int tmp;
		int b [4];
		int j1;
		int j2;
		bit last;
		bit fe;
		nrows = $urandom_range(1, max_rows);
		for (int r = 0; r < nrows; r++) begin
			width    = $urandom_range(1, max_width);
			mode     = $urandom_range(0, 9);
			pct_edge = $urandom_range(0, 100);
			pct_ero  = $urandom_range(0, 40);
			for (int k = 0; k < 4; k++) b[k] = $urandom_range(0, width);
			for (int x = 0; x < 3; x++) begin
				for (int y = 0; y < 3 - x; y++) begin
					if (b[y] > b[y + 1]) begin
						tmp = b[y];
						b[y] = b[y + 1];
						b[y + 1] = tmp;
					end
				end
			end
			if (mode == 7) begin
				tmp = b[0]; b[0] = b[3]; b[3] = tmp;
				tmp = b[1]; b[1] = b[2]; b[2] = tmp;
			end else if (mode == 8) begin
				for (int k = 0; k < 4; k++) b[k] = $urandom_range(0, 2048);
			end
			for (int c = 0; c < width; c++) begin
				j1 = (mode == 9) ? $urandom_range(0, 1) : 0;
				j2 = (mode == 9) ? $urandom_range(0, 1) : 0;
				last = (c == width - 1);
				fe = last && (r == nrows - 1);
				push_pixel(pick_level(pct_edge), pick_level(pct_ero), b[0], b[1] + j1,
				           b[2] + j2, b[3], fe ? bit'($urandom_range(0, 1)) : last, fe);
			end
		end
	endtask

	task automatic push_random_phase(input int n_items, input int max_rows);
		int start;
		start = beats_queued;
		while (beats_queued - start < n_items) push_random_frame(max_rows, 16);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single pixel frame; frame end alone closes the row.
		push_pixel(255, 255, 0, 1, 1, 1, 0, 1);
		// Strong level is exclusive, then a row with reversed boundaries.
		push_pixel(251, 251, 0, 1, 2, 3, 0, 0);
		push_pixel(250, 255, 0, 1, 2, 3, 0, 0);
		push_pixel(255, 250, 0, 1, 2, 3, 1, 0);
		push_pixel(255, 255, 3, 2, 1, 0, 0, 0);
		push_pixel(255, 255, 3, 2, 1, 0, 1, 1);
		// Counting starts mid-lane; the row-end beat widens the lane so it fails.
		push_pixel(255, 0, 0, 6, 6, 6, 0, 0);
		push_pixel(255, 0, 0, 6, 6, 6, 0, 0);
		push_pixel(255, 255, 0, 6, 6, 6, 0, 0);
		push_pixel(255, 0, 0, 6, 6, 6, 0, 0);
		push_pixel(0, 0, 0, 6, 6, 6, 0, 0);
		push_pixel(0, 255, 0, 7, 7, 7, 1, 0);
		push_pixel(0, 0, 2048, 2048, 2048, 2048, 0, 1);
		// Empty left lane, one strong pixel each in center and right.
		push_pixel(255, 255, 0, 0, 2, 4, 0, 0);
		push_pixel(0, 0, 0, 0, 2, 4, 0, 0);
		push_pixel(251, 251, 0, 0, 2, 4, 0, 0);
		push_pixel(0, 0, 0, 0, 2, 4, 1, 1);
		drain();

		set_reg(REG_ROW_OFFSET, 1023);
		set_reg(REG_SCAN_LAST_ROW, 1023);
		push_random_phase(130, 8);
		drain();

		set_reg(REG_ROW_OFFSET, 0);
		set_reg(REG_SCAN_LAST_ROW, 0);
		push_random_phase(130, 8);
		drain();

		set_reg(REG_ROW_OFFSET, $urandom_range(0, 1023));
		set_reg(REG_SCAN_LAST_ROW, 3);
		push_random_phase(100, 8);
		// Back-to-back frame ends while the receiver holds off fill the block.
		hold_req <= 1'b1;
		for (int k = 0; k < 40; k++)
			push_pixel(pick_level(60), pick_level(60), 0, 1, 1, 1, 0, 1);
		push_random_phase(80, 8);
		drain();

		set_reg(REG_SCAN_LAST_ROW, $urandom_range(0, 7));
		set_reg(REG_ROW_OFFSET, $urandom_range(0, 1023));
		push_random_phase(130, 8);
		drain();

		set_reg(REG_ROW_OFFSET, $urandom_range(0, 1023));
		set_reg(REG_SCAN_LAST_ROW, $urandom_range(0, 1023));
		push_random_phase(130, 8);
		drain();

		set_reg(REG_ROW_OFFSET, 1023);
		set_reg(REG_SCAN_LAST_ROW, 2);
		push_random_phase(80, 6);
		drain();

		quiet <= 1'b1;
		set_reg(REG_ROW_OFFSET, 517);
		set_reg(REG_SCAN_LAST_ROW, 511);
		push_random_phase(130, 8);
		drain();

		repeat (20) @(posedge clk);
		if (expected_reports.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_reports.size()));
		if (error_count == 0)
			$display("lane_occupancy_row_scanner_top_tb: done, clean");
		else
			$display("lane_occupancy_row_scanner_top_tb: done, errors");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/lors_pkg.sv
rtl/core/lane_occupancy_row_scanner_top.sv
tb/lane_occupancy_row_scanner_top_tb.sv
